>>> src/pnr_pkg.sv
package pnr_pkg;

   // fixed-point format of coordinates, pixels and residuals
   localparam int FRAC_BITS = 16;
   localparam int XW        = 32;   // width of every item field
   localparam int CFG_W     = 31;   // width of every control register
   localparam int UW        = 36;   // width of 2*(q x P)
   localparam int CW        = 40;   // width of camera-frame coordinates

   // divider geometry
   localparam int QUO_BITS  = 33;
   localparam int NUM_W     = CW + FRAC_BITS;
   localparam int CMP_W     = CW + QUO_BITS;
   localparam int DIV_LAT   = QUO_BITS + 2;

   // skid queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // control register indexes
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_FOCAL_X   = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FOCAL_Y   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_X  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CENTER_Y  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_DEPTH = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PENALTY   = 3'd5;

   typedef struct packed {
      logic [CFG_W-1:0] focal_x;
      logic [CFG_W-1:0] focal_y;
      logic [CFG_W-1:0] center_x;
      logic [CFG_W-1:0] center_y;
      logic [CFG_W-1:0] min_depth;
      logic [CFG_W-1:0] penalty;
   } pnr_cfg_type;

   // one classified point on its way from front to back
   typedef struct packed {
      logic signed [CW-1:0] cam_x;
      logic signed [CW-1:0] cam_y;
      logic signed [CW-1:0] cam_z;
      logic                 behind;
      logic signed [XW-1:0] seen_u;
      logic signed [XW-1:0] seen_v;
   } pnr_point_type;

   typedef struct packed {
      logic full;
      logic empty;
   } pnr_qstat_type;

endpackage

>>> src/pnr_front.sv
module pnr_front import pnr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic signed [XW-1:0] req_trans_x,
   input  logic signed [XW-1:0] req_trans_y,
   input  logic signed [XW-1:0] req_trans_z,
   input  logic signed [XW-1:0] req_quat_x,
   input  logic signed [XW-1:0] req_quat_y,
   input  logic signed [XW-1:0] req_quat_z,
   input  logic signed [XW-1:0] req_quat_w,
   input  logic signed [XW-1:0] req_world_x,
   input  logic signed [XW-1:0] req_world_y,
   input  logic signed [XW-1:0] req_world_z,
   input  logic signed [XW-1:0] req_seen_u,
   input  logic signed [XW-1:0] req_seen_v,
   input  pnr_cfg_type          cfg,
   input  pnr_qstat_type        q_stat,
   output logic                 push,
   output pnr_point_type        push_data
);

   localparam int STAGES = 6;
   localparam logic signed [63:0] RND64 = 64'sd536870912;
   localparam logic signed [62:0] RND63 = 63'sd536870912;
   localparam logic signed [XW-1:0] Q_ONE = 32'sd1073741824;

   typedef struct packed {
      logic signed [XW-1:0] tx, ty, tz, px, py, pz, su, sv;
   } carry_type;

   typedef struct packed {
      logic signed [XW-1:0] qx, qy, qz, qw;
   } quat_type;

   function automatic logic signed [XW-1:0] clamp_q30(input logic signed [XW-1:0] v);
      logic signed [XW-1:0] r;
      r = v;
      if (v > Q_ONE) r = Q_ONE;
      if (v < -Q_ONE) r = -Q_ONE;
      return r;
   endfunction

   logic [STAGES-1:0]    vld_ff;
   logic                 adv;
   carry_type            car_ff [STAGES];
   quat_type             quat_ff [3];
   quat_type             quat_in;
   logic signed [63:0]   prod_ff [6];
   logic signed [63:0]   prod_in [6];
   logic signed [63:0]   dif [3];
   logic signed [63:0]   dsh [3];
   logic signed [UW-1:0] u_ff [3];
   logic signed [UW-1:0] u_in [3];
   logic signed [XW-1:0] a_sel [9];
   logic signed [UW-1:0] u_sel [9];
   logic signed [37:0]   phi_ff [9];
   logic signed [37:0]   phi_in [9];
   logic signed [62:0]   plo_ff [9];
   logic signed [62:0]   plo_in [9];
   logic signed [62:0]   plo_rnd [9];
   logic signed [62:0]   plo_sh [9];
   logic signed [CW-1:0] term_ff [9];
   logic signed [CW-1:0] term_in [9];
   logic signed [CW-1:0] cam_x_ff, cam_y_ff, cam_z_ff;
   logic signed [CW-1:0] cam_x_in, cam_y_in, cam_z_in;

   // hold the pipe only when the last stage cannot move into the queue
   assign adv       = !(vld_ff[STAGES-1] && q_stat.full);
   assign req_stall = !adv;
   assign push      = vld_ff[STAGES-1] && !q_stat.full;

   // clamp quaternion parts on entry
   always_comb begin
      quat_in.qx = clamp_q30(req_quat_x);
      quat_in.qy = clamp_q30(req_quat_y);
      quat_in.qz = clamp_q30(req_quat_z);
      quat_in.qw = clamp_q30(req_quat_w);
   end

   // cross-product terms of q x P
   always_comb begin
      prod_in[0] = quat_ff[0].qy * car_ff[0].pz;
      prod_in[1] = quat_ff[0].qz * car_ff[0].py;
      prod_in[2] = quat_ff[0].qz * car_ff[0].px;
      prod_in[3] = quat_ff[0].qx * car_ff[0].pz;
      prod_in[4] = quat_ff[0].qx * car_ff[0].py;
      prod_in[5] = quat_ff[0].qy * car_ff[0].px;
   end

   // round to Q.FRAC and double: u = 2 (q x P)
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         dif[i]  = prod_ff[2*i] - prod_ff[2*i+1] + RND64;
         dsh[i]  = dif[i] >>> 30;
         u_in[i] = $signed({dsh[i][UW-2:0], 1'b0});
      end
   end

   // operand pairs of w*u + q x u
   always_comb begin
      a_sel[0] = quat_ff[2].qw; u_sel[0] = u_ff[0];
      a_sel[1] = quat_ff[2].qy; u_sel[1] = u_ff[2];
      a_sel[2] = quat_ff[2].qz; u_sel[2] = u_ff[1];
      a_sel[3] = quat_ff[2].qw; u_sel[3] = u_ff[1];
      a_sel[4] = quat_ff[2].qz; u_sel[4] = u_ff[0];
      a_sel[5] = quat_ff[2].qx; u_sel[5] = u_ff[2];
      a_sel[6] = quat_ff[2].qw; u_sel[6] = u_ff[2];
      a_sel[7] = quat_ff[2].qx; u_sel[7] = u_ff[1];
      a_sel[8] = quat_ff[2].qy; u_sel[8] = u_ff[0];
      for (int i = 0; i < 9; i++) begin
         phi_in[i] = a_sel[i] * $signed(u_sel[i][UW-1:30]);
         plo_in[i] = a_sel[i] * $signed({1'b0, u_sel[i][29:0]});
      end
   end

   // recombine split products with round half up
   always_comb begin
      for (int i = 0; i < 9; i++) begin
         plo_rnd[i] = plo_ff[i] + RND63;
         plo_sh[i]  = plo_rnd[i] >>> 30;
         term_in[i] = CW'(phi_ff[i]) + $signed(plo_sh[i][CW-1:0]);
      end
   end

   // camera-frame point
   always_comb begin
      cam_x_in = CW'(car_ff[4].px) + term_ff[0] + term_ff[1] - term_ff[2] + CW'(car_ff[4].tx);
      cam_y_in = CW'(car_ff[4].py) + term_ff[3] + term_ff[4] - term_ff[5] + CW'(car_ff[4].ty);
      cam_z_in = CW'(car_ff[4].pz) + term_ff[6] + term_ff[7] - term_ff[8] + CW'(car_ff[4].tz);
   end

   // classify depth and hand off
   always_comb begin
      push_data.cam_x  = cam_x_ff;
      push_data.cam_y  = cam_y_ff;
      push_data.cam_z  = cam_z_ff;
      push_data.behind = cam_z_ff <= $signed({{(CW-CFG_W){1'b0}}, cfg.min_depth});
      push_data.seen_u = car_ff[STAGES-1].su;
      push_data.seen_v = car_ff[STAGES-1].sv;
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[STAGES-2:0], req_valid};
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (adv) begin
         car_ff[0] <= '{req_trans_x, req_trans_y, req_trans_z, req_world_x,
                        req_world_y, req_world_z, req_seen_u, req_seen_v};
         for (int i = 1; i < STAGES; i++) car_ff[i] <= car_ff[i-1];
         quat_ff[0] <= quat_in;
         quat_ff[1] <= quat_ff[0];
         quat_ff[2] <= quat_ff[1];
         prod_ff    <= prod_in;
         u_ff       <= u_in;
         phi_ff     <= phi_in;
         plo_ff     <= plo_in;
         term_ff    <= term_in;
         cam_x_ff   <= cam_x_in;
         cam_y_ff   <= cam_y_in;
         cam_z_ff   <= cam_z_in;
      end
   end

endmodule

>>> src/pnr_queue.sv
module pnr_queue import pnr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  pnr_point_type push_data,
   input  logic          pop,
   output pnr_point_type head,
   output pnr_qstat_type q_stat
);

   pnr_point_type     mem [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] cnt_ff;

   assign head         = mem[rd_ptr_ff];
   assign q_stat.full  = cnt_ff == QCNT_W'(QUEUE_DEPTH);
   assign q_stat.empty = cnt_ff == '0;

   // write entry
   always_ff @(posedge clock) begin
      if (push) mem[wr_ptr_ff] <= push_data;
   end

   // move pointers and count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         if (push && !pop) cnt_ff <= cnt_ff + 1'b1;
         else if (pop && !push) cnt_ff <= cnt_ff - 1'b1;
      end
   end

endmodule

>>> src/pnr_div.sv
module pnr_div import pnr_pkg::*; (
   input  logic                 clock,
   input  logic                 adv,
   input  logic signed [CW-1:0] num,
   input  logic signed [CW-1:0] den,
   output logic signed [XW-1:0] ratio
);

   localparam logic [QUO_BITS-1:0] POS_MAX = QUO_BITS'(33'h0_7FFF_FFFF);
   localparam logic [QUO_BITS-1:0] NEG_MAX = QUO_BITS'(33'h0_8000_0000);

   logic [NUM_W-1:0]    rem_ff [QUO_BITS+1];
   logic [QUO_BITS-1:0] quo_ff [QUO_BITS+1];
   logic [CW-1:0]       den_ff [QUO_BITS+1];
   logic                neg_ff [QUO_BITS+1];
   logic                ovf_ff [QUO_BITS+1];
   logic [NUM_W-1:0]    rem_in [QUO_BITS+1];
   logic [QUO_BITS-1:0] quo_in [QUO_BITS+1];
   logic [CW-1:0]       mag;
   logic signed [XW-1:0] ratio_ff, ratio_in;
   logic [QUO_BITS-1:0] q_fin;

   // magnitude of the scaled numerator
   always_comb begin
      mag = num[CW-1] ? CW'(-num) : CW'(num);
      rem_in[0] = {mag, {FRAC_BITS{1'b0}}};
      quo_in[0] = '0;
   end

   // one restoring step per stage, quotient bit QUO_BITS-j at stage j
   for (genvar j = 1; j <= QUO_BITS; j++) begin : g_step
      logic [CMP_W-1:0] dsh;
      logic [CMP_W-1:0] rz;
      always_comb begin
         dsh = CMP_W'(den_ff[j-1]) << (QUO_BITS - j);
         rz  = CMP_W'(rem_ff[j-1]);
         quo_in[j] = quo_ff[j-1];
         rem_in[j] = rem_ff[j-1];
         if (rz >= dsh) begin
            rem_in[j] = NUM_W'(rz - dsh);
            quo_in[j][QUO_BITS-j] = 1'b1;
         end
      end
   end

   // saturate signed quotient
   always_comb begin
      q_fin = quo_ff[QUO_BITS];
      if (neg_ff[QUO_BITS]) begin
         if (ovf_ff[QUO_BITS] || q_fin > NEG_MAX) ratio_in = $signed(32'h8000_0000);
         else ratio_in = XW'(-$signed(q_fin));
      end else begin
         if (ovf_ff[QUO_BITS] || q_fin > POS_MAX) ratio_in = $signed(32'h7FFF_FFFF);
         else ratio_in = $signed(q_fin[XW-1:0]);
      end
   end

   // advance divider stages
   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= rem_in[0];
         quo_ff[0] <= quo_in[0];
         den_ff[0] <= den;
         neg_ff[0] <= num[CW-1];
         ovf_ff[0] <= CMP_W'(rem_in[0]) >= {den, {QUO_BITS{1'b0}}};
         for (int j = 1; j <= QUO_BITS; j++) begin
            rem_ff[j] <= rem_in[j];
            quo_ff[j] <= quo_in[j];
            den_ff[j] <= den_ff[j-1];
            neg_ff[j] <= neg_ff[j-1];
            ovf_ff[j] <= ovf_ff[j-1];
         end
         ratio_ff <= ratio_in;
      end
   end

   assign ratio = ratio_ff;

endmodule

>>> src/pnr_back.sv
module pnr_back import pnr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  pnr_qstat_type        q_stat,
   input  pnr_point_type        head,
   output logic                 pop,
   input  pnr_cfg_type          cfg,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [XW-1:0] rsp_resid_u,
   output logic signed [XW-1:0] rsp_resid_v,
   output logic                 rsp_behind_camera
);

   localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

   typedef struct packed {
      logic                 behind;
      logic signed [XW-1:0] su;
      logic signed [XW-1:0] sv;
   } side_type;

   function automatic logic signed [XW-1:0] resid(input logic signed [63:0] prod,
                                                  input logic [CFG_W-1:0] center,
                                                  input logic signed [XW-1:0] seen);
      logic signed [63:0] sc;
      logic signed [63:0] sum;
      logic signed [XW-1:0] r;
      sc  = (prod + HALF) >>> FRAC_BITS;
      sum = sc + $signed({{(64-CFG_W){1'b0}}, center}) - 64'(seen);
      if (sum > 64'sd2147483647) r = $signed(32'h7FFF_FFFF);
      else if (sum < -64'sd2147483648) r = $signed(32'h8000_0000);
      else r = sum[XW-1:0];
      return r;
   endfunction

   logic                 adv;
   logic [DIV_LAT-1:0]   vld_ff;
   side_type             side_ff [DIV_LAT];
   logic signed [XW-1:0] ratio_x, ratio_y;
   logic                 mul_vld_ff;
   side_type             mul_side_ff;
   logic signed [63:0]   prod_x_ff, prod_y_ff;
   logic                 out_vld_ff;
   logic signed [XW-1:0] out_u_ff, out_v_ff, out_u_in, out_v_in;
   logic                 out_b_ff;

   // hold everything while the output beat waits
   assign adv = !(out_vld_ff && rsp_stall);
   assign pop = adv && !q_stat.empty;

   pnr_div u_div_x (
      .clock (clock),
      .adv   (adv),
      .num   (head.cam_x),
      .den   (head.cam_z),
      .ratio (ratio_x)
   );

   pnr_div u_div_y (
      .clock (clock),
      .adv   (adv),
      .num   (head.cam_y),
      .den   (head.cam_z),
      .ratio (ratio_y)
   );

   // final residuals or penalty
   always_comb begin
      if (mul_side_ff.behind) begin
         out_u_in = $signed({1'b0, cfg.penalty});
         out_v_in = $signed({1'b0, cfg.penalty});
      end else begin
         out_u_in = resid(prod_x_ff, cfg.center_x, mul_side_ff.su);
         out_v_in = resid(prod_y_ff, cfg.center_y, mul_side_ff.sv);
      end
   end

   // advance valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff     <= '0;
         mul_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (adv) begin
         vld_ff     <= {vld_ff[DIV_LAT-2:0], pop};
         mul_vld_ff <= vld_ff[DIV_LAT-1];
         out_vld_ff <= mul_vld_ff;
      end
   end

   // advance payload
   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= '{head.behind, head.seen_u, head.seen_v};
         for (int i = 1; i < DIV_LAT; i++) side_ff[i] <= side_ff[i-1];
         mul_side_ff <= side_ff[DIV_LAT-1];
         prod_x_ff   <= $signed({1'b0, cfg.focal_x}) * ratio_x;
         prod_y_ff   <= $signed({1'b0, cfg.focal_y}) * ratio_y;
         out_u_ff    <= out_u_in;
         out_v_ff    <= out_v_in;
         out_b_ff    <= mul_side_ff.behind;
      end
   end

   assign rsp_valid         = out_vld_ff;
   assign rsp_resid_u       = out_u_ff;
   assign rsp_resid_v       = out_v_ff;
   assign rsp_behind_camera = out_b_ff;

endmodule

>>> src/pinhole_reprojection_residual_top.sv
// Pinhole reprojection residual engine.
// Request channel (req_*): one beat carries a camera pose (translation and
// quaternion), a world point and an observed pixel, taken when req_valid is
// high and req_stall low. Response channel (rsp_*): one beat per request, in
// order, with the two pixel residuals and the behind-camera flag.
// Control port (csr_*): focal lengths, principal point, minimum depth and
// penalty; write only while the engine is empty.
// Throughput: one beat per cycle while rsp_stall is low. A request passes
// through the transform front end, the skid queue, the restoring divider
// (one quotient bit per stage over 33 stages) and then the focal multiply
// and final add/saturate.
// The front end and back end stall independently; a 4-entry queue sits
// between them. While rsp_stall is high the back end holds its output beat
// and the queue fills; once full with a point waiting, req_stall rises.
// Reset clears all valid state and loads the default camera intrinsics.
module pinhole_reprojection_residual_top import pnr_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic signed [XW-1:0] req_trans_x,
   input  logic signed [XW-1:0] req_trans_y,
   input  logic signed [XW-1:0] req_trans_z,
   input  logic signed [XW-1:0] req_quat_x,
   input  logic signed [XW-1:0] req_quat_y,
   input  logic signed [XW-1:0] req_quat_z,
   input  logic signed [XW-1:0] req_quat_w,
   input  logic signed [XW-1:0] req_world_x,
   input  logic signed [XW-1:0] req_world_y,
   input  logic signed [XW-1:0] req_world_z,
   input  logic signed [XW-1:0] req_seen_u,
   input  logic signed [XW-1:0] req_seen_v,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic signed [XW-1:0] rsp_resid_u,
   output logic signed [XW-1:0] rsp_resid_v,
   output logic                 rsp_behind_camera,
   input  logic                 csr_wr_en,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   pnr_cfg_type   cfg_ff;
   pnr_qstat_type q_stat;
   pnr_point_type push_data, head;
   logic          push, pop;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.focal_x   <= CFG_W'(24742151);
         cfg_ff.focal_y   <= CFG_W'(24720824);
         cfg_ff.center_x  <= CFG_W'(21508481);
         cfg_ff.center_y  <= CFG_W'(15756616);
         cfg_ff.min_depth <= CFG_W'(655);
         cfg_ff.penalty   <= CFG_W'(65536000);
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_FOCAL_X:   cfg_ff.focal_x   <= csr_wdata;
            CSR_FOCAL_Y:   cfg_ff.focal_y   <= csr_wdata;
            CSR_CENTER_X:  cfg_ff.center_x  <= csr_wdata;
            CSR_CENTER_Y:  cfg_ff.center_y  <= csr_wdata;
            CSR_MIN_DEPTH: cfg_ff.min_depth <= csr_wdata;
            CSR_PENALTY:   cfg_ff.penalty   <= csr_wdata;
            default: ;
         endcase
      end
   end

   pnr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_trans_x (req_trans_x),
      .req_trans_y (req_trans_y),
      .req_trans_z (req_trans_z),
      .req_quat_x  (req_quat_x),
      .req_quat_y  (req_quat_y),
      .req_quat_z  (req_quat_z),
      .req_quat_w  (req_quat_w),
      .req_world_x (req_world_x),
      .req_world_y (req_world_y),
      .req_world_z (req_world_z),
      .req_seen_u  (req_seen_u),
      .req_seen_v  (req_seen_v),
      .cfg         (cfg_ff),
      .q_stat      (q_stat),
      .push        (push),
      .push_data   (push_data)
   );

   pnr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .head      (head),
      .q_stat    (q_stat)
   );

   pnr_back u_back (
      .clock             (clock),
      .reset             (reset),
      .q_stat            (q_stat),
      .head              (head),
      .pop               (pop),
      .cfg               (cfg_ff),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_resid_u       (rsp_resid_u),
      .rsp_resid_v       (rsp_resid_v),
      .rsp_behind_camera (rsp_behind_camera)
   );

endmodule
